// ===== rtl/kcfr_pkg.sv =====
// Shared types, constants and helper functions of the keyed command frame receiver.
package kcfr_pkg;

    localparam int FRAME_LEN = 4;
    localparam int TIMER_W   = 10;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 10'd1023;
    localparam int UPG_LEN   = 9;

    localparam logic [TIMER_W-1:0] GAP_TIMEOUT_RST   = 10'd300;
    localparam logic [TIMER_W-1:0] PROMPT_PERIOD_RST = 10'd500;

    // Register indexes on the configuration port.
    localparam logic REG_GAP_TIMEOUT   = 1'b0;
    localparam logic REG_PROMPT_PERIOD = 1'b1;

    // Command codes carried in frame byte 1.
    localparam logic [7:0] CMD_CH1    = 8'h08;
    localparam logic [7:0] CMD_CH2    = 8'h0c;
    localparam logic [7:0] CMD_CH3    = 8'h12;
    localparam logic [7:0] CMD_HEATER = 8'h1c;

    // Action codes on the result channel.
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_CH1    = 3'd1;
    localparam logic [2:0] ACT_CH2    = 3'd2;
    localparam logic [2:0] ACT_CH3    = 3'd3;
    localparam logic [2:0] ACT_HEATER = 3'd4;

    // Key frame selector codes in frame byte 0.
    localparam logic [7:0] KSEL_B1 = 8'd1;
    localparam logic [7:0] KSEL_B2 = 8'd2;
    localparam logic [7:0] KSEL_B3 = 8'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       link_connected;
    } kcfr_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] action_value;
        logic       beep;
        logic       key_learned;
        logic       upgrade_request;
        logic       send_prompt;
    } kcfr_res_t;

    typedef struct packed {
        logic [TIMER_W-1:0] gap_timeout;
        logic [TIMER_W-1:0] prompt_period;
    } kcfr_cfg_t;

    // Characters of the upgrade text, indexed by the match position.
    function automatic logic [7:0] upg_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = "F";
            4'd1: c = "W";
            4'd2: c = "U";
            4'd3: c = "P";
            4'd4: c = "G";
            4'd5: c = "R";
            4'd6: c = "A";
            4'd7: c = "D";
            4'd8: c = "E";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Key weight of one selector bit; the largest total is 214, so 8 bits hold it.
    function automatic logic [7:0] key_weight(input logic [2:0] bitpos);
        logic [7:0] w;
        case (bitpos)
            3'd0: w = 8'd6;
            3'd1: w = 8'd9;
            3'd2: w = 8'd16;
            3'd3: w = 8'd25;
            3'd4: w = 8'd36;
            3'd5: w = 8'd49;
            3'd6: w = 8'd64;
            3'd7: w = 8'd9;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] key_sum(input logic [7:0] sel);
        logic [7:0] s;
        s = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (sel[i]) begin
                s = s + key_weight(3'(i));
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/keyed_command_frame_receiver.sv =====
// Top level of the keyed command frame receiver: stream ports, input and result registers.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tuser: req_type; s_tdata: rx_byte, link_connected
//  m_        out        m_tvalid/m_tready   m_tuser: action; m_tdata: action_value and flags
//  APB       in/out     psel/penable        byte_gap_timeout_ms at 0x0, prompt_period_ms at 0x4
//
// Every input word gives exactly one result word. A word is held in the input register,
// is processed in a single pass against the receiver state, and lands in the result
// register; one word is taken every cycle while the result side is not stalled.
// The input register frees up whenever the result register is empty or being drained;
// a stalled result holds the next word back only once the input register is full too.
// Reset is synchronous and active low; it empties both registers, clears the frame,
// key, matcher and timers, and loads the register defaults (300 ms and 500 ms).
module keyed_command_frame_receiver import kcfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] link_connected, [15:9] zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] action_value, [8] beep, [9] key_learned,
                                   // [10] upgrade_request, [11] send_prompt, [15:12] zero
    output logic [2:0]  m_tuser,   // [2:0] action
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kcfr_cfg_t  cfg;
    kcfr_item_t in_item_reg;
    logic       in_vld_reg;
    kcfr_res_t  core_res;
    kcfr_res_t  out_res_reg;
    logic       out_vld_reg;
    logic       adv;
    logic       s_fire;

    kcfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The word in the input register moves on when the result register can take it.
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    kcfr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_vld_reg <= 1'b1;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.req_type       <= s_tuser;
            in_item_reg.rx_byte        <= s_tdata[7:0];
            in_item_reg.link_connected <= s_tdata[8];
        end
        if (adv) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {4'd0, out_res_reg.send_prompt, out_res_reg.upgrade_request,
                       out_res_reg.key_learned, out_res_reg.beep, out_res_reg.action_value};

endmodule

// ===== rtl/kcfr_cfg.sv =====
// Configuration register file behind the APB-style port.
module kcfr_cfg import kcfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output kcfr_cfg_t   cfg
);

    logic [TIMER_W-1:0] gap_timeout_reg;
    logic [TIMER_W-1:0] prompt_period_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_timeout_reg   <= GAP_TIMEOUT_RST;
            prompt_period_reg <= PROMPT_PERIOD_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_GAP_TIMEOUT:   gap_timeout_reg   <= pwdata[TIMER_W-1:0];
                REG_PROMPT_PERIOD: prompt_period_reg <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_GAP_TIMEOUT:   prdata = {22'd0, gap_timeout_reg};
            REG_PROMPT_PERIOD: prdata = {22'd0, prompt_period_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.gap_timeout   = gap_timeout_reg;
    assign cfg.prompt_period = prompt_period_reg;

endmodule

// ===== rtl/kcfr_core.sv =====
// Receiver state and the single-pass logic that turns one word into one result.
module kcfr_core import kcfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  kcfr_item_t item,
    input  kcfr_cfg_t  cfg,
    output kcfr_res_t  res
);

    logic [1:0]         frame_count_reg, frame_count_next;
    logic [7:0]         frame_bytes_reg [FRAME_LEN-1];
    logic [TIMER_W-1:0] gap_timer_reg, gap_timer_next;
    logic               have_key_reg, have_key_next;
    logic [7:0]         session_key_reg, session_key_next;
    logic [3:0]         match_count_reg, match_count_next;
    logic [TIMER_W-1:0] prompt_timer_reg, prompt_timer_next;

    logic [TIMER_W-1:0] gap_inc, prompt_inc;
    logic               have_key_lnk;
    logic [1:0]         fc_eff;
    logic               store_byte;
    logic [7:0]         key_sel;
    logic               key_sel_ok;
    logic [10:0]        check_sum;
    logic               is_byte;

    assign is_byte = !item.req_type;

    always_comb begin
        gap_inc    = gap_timer_reg;
        prompt_inc = prompt_timer_reg;
        if (item.req_type && gap_timer_reg < TIMER_MAX) begin
            gap_inc = gap_timer_reg + 1'b1;
        end
        if (item.req_type && prompt_timer_reg < TIMER_MAX) begin
            prompt_inc = prompt_timer_reg + 1'b1;
        end

        have_key_lnk = item.link_connected && have_key_reg;

        // A long enough silence throws away a partial frame.
        fc_eff     = (gap_inc >= cfg.gap_timeout) ? 2'd0 : frame_count_reg;
        store_byte = is_byte && (fc_eff < 2'(FRAME_LEN - 1));

        case (frame_bytes_reg[0])
            KSEL_B1: begin key_sel = frame_bytes_reg[1]; key_sel_ok = 1'b1; end
            KSEL_B2: begin key_sel = frame_bytes_reg[2]; key_sel_ok = 1'b1; end
            KSEL_B3: begin key_sel = item.rx_byte;       key_sel_ok = 1'b1; end
            default: begin key_sel = 8'd0;               key_sel_ok = 1'b0; end
        endcase

        check_sum = 11'(frame_bytes_reg[1]) * 11'd3 + 11'(frame_bytes_reg[2]) * 11'd2;

        res               = '0;
        frame_count_next  = frame_count_reg;
        gap_timer_next    = gap_inc;
        have_key_next     = have_key_lnk;
        session_key_next  = session_key_reg;
        match_count_next  = match_count_reg;
        prompt_timer_next = prompt_inc;

        if (item.link_connected && !have_key_reg && prompt_inc >= cfg.prompt_period) begin
            prompt_timer_next = '0;
            res.send_prompt   = 1'b1;
        end

        if (is_byte) begin
            // The byte that breaks a partial match is not retried as a first character.
            if (match_count_reg < 4'(UPG_LEN) && item.rx_byte == upg_char(match_count_reg)) begin
                if (match_count_reg == 4'(UPG_LEN - 1)) begin
                    match_count_next    = 4'd0;
                    res.upgrade_request = 1'b1;
                end else begin
                    match_count_next = match_count_reg + 1'b1;
                end
            end else begin
                match_count_next = 4'd0;
            end

            gap_timer_next = '0;

            if (store_byte) begin
                frame_count_next = fc_eff + 1'b1;
            end else begin
                frame_count_next = 2'd0;
                if (have_key_lnk) begin
                    if (frame_bytes_reg[0] == session_key_reg
                            && {3'd0, item.rx_byte} == check_sum) begin
                        case (frame_bytes_reg[1])
                            CMD_CH1:    res.action = ACT_CH1;
                            CMD_CH2:    res.action = ACT_CH2;
                            CMD_CH3:    res.action = ACT_CH3;
                            CMD_HEATER: res.action = ACT_HEATER;
                            default:    res.action = ACT_NONE;
                        endcase
                        if (res.action != ACT_NONE) begin
                            res.action_value = frame_bytes_reg[2];
                            res.beep         = 1'b1;
                        end
                    end
                end else if (key_sel_ok) begin
                    session_key_next = key_sum(key_sel);
                    have_key_next    = 1'b1;
                    res.key_learned  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg  <= 2'd0;
            gap_timer_reg    <= '0;
            have_key_reg     <= 1'b0;
            session_key_reg  <= 8'd0;
            match_count_reg  <= 4'd0;
            prompt_timer_reg <= '0;
        end else if (step) begin
            frame_count_reg  <= frame_count_next;
            gap_timer_reg    <= gap_timer_next;
            have_key_reg     <= have_key_next;
            session_key_reg  <= session_key_next;
            match_count_reg  <= match_count_next;
            prompt_timer_reg <= prompt_timer_next;
        end
    end

    // Frame bytes carry no reset; each is read only after this frame wrote it.
    always_ff @(posedge aclk) begin
        if (step && store_byte) begin
            frame_bytes_reg[fc_eff] <= item.rx_byte;
        end
    end

endmodule

// ===== rtl/kcfr_checker.sv =====
// Port-level checker for the receiver, bound to the top level.
module kcfr_port_checker import kcfr_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A beep goes with a command and only with one.
    a_beep_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == (m_tuser != ACT_NONE)))
        else $error("beep and action disagree");

    // A frame either teaches the key or runs a command, never both.
    a_key_or_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[9] && m_tdata[8]))
        else $error("key learned and command in one result");

    // Without a command the value field stays zero.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACT_NONE) |-> (m_tdata[7:0] == 8'd0))
        else $error("action value without action");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind keyed_command_frame_receiver kcfr_port_checker u_kcfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/kcfr_checker.sv =====
// Result checker of the keyed command frame receiver: predicts every result word and compares it.
`timescale 1ns / 100ps
module kcfr_checker import kcfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] link_connected, [15:9] zero
    input  logic        s_tuser,   // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] action_value, [8] beep, [9] key_learned,
                                   // [10] upgrade_request, [11] send_prompt, [15:12] zero
    input  logic [2:0]  m_tuser,   // [2:0] action
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          results_due
);

    localparam logic [71:0] UPG_TEXT    = "FWUPGRADE";
    localparam logic [63:0] KEY_WEIGHTS = {8'd9, 8'd64, 8'd49, 8'd36, 8'd25, 8'd16, 8'd9, 8'd6};

    kcfr_res_t          due_results[$];

    logic [TIMER_W-1:0] gap_timeout;
    logic [TIMER_W-1:0] prompt_period;
    logic [1:0]         frame_pos;
    logic [7:0]         frame_buf [0:FRAME_LEN-2];
    logic [TIMER_W-1:0] gap_ms;
    logic [TIMER_W-1:0] prompt_ms;
    logic               key_known;
    logic [7:0]         learned_key;
    logic [3:0]         match_pos;

    // Advances the predicted receiver state by one input word and returns its result word.
    task automatic predict_word_result(input logic tick, input logic [7:0] rx, input logic link,
                                       output kcfr_res_t res);
        logic [7:0] sel;
        logic       sel_ok;
        logic [2:0] act;
        int         sum;
        res = '0;
        if (tick) begin
            if (gap_ms != TIMER_MAX) gap_ms = gap_ms + 1'b1;
            if (prompt_ms != TIMER_MAX) prompt_ms = prompt_ms + 1'b1;
        end
        if (!link) begin
            key_known = 1'b0;
        end else if (!key_known && prompt_ms >= prompt_period) begin
            prompt_ms = '0;
            res.send_prompt = 1'b1;
        end
        if (!tick) begin
            // A mismatching byte drops the count without being tried as a first character.
            if (match_pos < UPG_LEN && rx == UPG_TEXT[8 * (UPG_LEN - 1 - match_pos) +: 8]) begin
                match_pos = match_pos + 1'b1;
                if (match_pos == UPG_LEN) begin
                    match_pos = '0;
                    res.upgrade_request = 1'b1;
                end
            end else begin
                match_pos = '0;
            end
            if (gap_ms >= gap_timeout) frame_pos = '0;
            gap_ms = '0;
            if (frame_pos < FRAME_LEN - 1) begin
                frame_buf[frame_pos] = rx;
                frame_pos = frame_pos + 1'b1;
            end else begin
                if (key_known) begin
                    case (frame_buf[1])
                        CMD_CH1:    act = ACT_CH1;
                        CMD_CH2:    act = ACT_CH2;
                        CMD_CH3:    act = ACT_CH3;
                        CMD_HEATER: act = ACT_HEATER;
                        default:    act = ACT_NONE;
                    endcase
                    // The check byte is compared against the full sum, not its low byte.
                    if (frame_buf[0] == learned_key && act != ACT_NONE &&
                        int'(rx) == 3 * int'(frame_buf[1]) + 2 * int'(frame_buf[2])) begin
                        res.action       = act;
                        res.action_value = frame_buf[2];
                        res.beep         = 1'b1;
                    end
                end else begin
                    sel_ok = 1'b1;
                    case (frame_buf[0])
                        KSEL_B1: sel = frame_buf[1];
                        KSEL_B2: sel = frame_buf[2];
                        KSEL_B3: sel = rx;
                        default: begin
                            sel    = '0;
                            sel_ok = 1'b0;
                        end
                    endcase
                    if (sel_ok) begin
                        sum = 0;
                        for (int i = 0; i < 8; i++) begin
                            if (sel[i]) sum += KEY_WEIGHTS[8 * i +: 8];
                        end
                        learned_key     = 8'(sum);
                        key_known       = 1'b1;
                        res.key_learned = 1'b1;
                    end
                end
                frame_pos = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge aclk) begin : watch
        kcfr_res_t want;
        kcfr_res_t got;
        if (!aresetn) begin
            gap_timeout   = GAP_TIMEOUT_RST;
            prompt_period = PROMPT_PERIOD_RST;
            frame_pos     = '0;
            for (int i = 0; i < FRAME_LEN - 1; i++) frame_buf[i] = '0;
            gap_ms        = '0;
            prompt_ms     = '0;
            key_known     = 1'b0;
            learned_key   = '0;
            match_pos     = '0;
            due_results.delete();
            fail_count    = 0;
            results_due  <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_GAP_TIMEOUT) gap_timeout = pwdata[TIMER_W-1:0];
                else prompt_period = pwdata[TIMER_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                predict_word_result(s_tuser, s_tdata[7:0], s_tdata[8], want);
                due_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.action          = m_tuser;
                got.action_value    = m_tdata[7:0];
                got.beep            = m_tdata[8];
                got.key_learned     = m_tdata[9];
                got.upgrade_request = m_tdata[10];
                got.send_prompt     = m_tdata[11];
                if (due_results.size() == 0) begin
                    $error("unexpected result word: action %0d, action_value %0d",
                           got.action, got.action_value);
                    fail_count = fail_count + 1;
                end else begin
                    want = due_results.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("action_value", want.action_value, got.action_value);
                    check_field("beep", want.beep, got.beep);
                    check_field("key_learned", want.key_learned, got.key_learned);
                    check_field("upgrade_request", want.upgrade_request, got.upgrade_request);
                    check_field("send_prompt", want.send_prompt, got.send_prompt);
                end
            end
            results_due <= due_results.size();
        end
    end

endmodule

// ===== dv/tb_keyed_command_frame_receiver.sv =====
// Testbench top of the keyed command frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_keyed_command_frame_receiver import kcfr_pkg::*;;

    // The watchdog ends the run after this many cycles in which no word moves on any port.
    localparam int QUIET_LIMIT     = 4000;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 110;
    // Margin after the block has drained, for the final quiet check.
    localparam int TAIL_CYCLES     = 8;
    localparam logic [71:0] UPG_TEXT    = "FWUPGRADE";
    localparam logic [63:0] KEY_WEIGHTS = {8'd9, 8'd64, 8'd49, 8'd36, 8'd25, 8'd16, 8'd9, 8'd6};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] rx_byte, [8] link_connected, [15:9] zero
    logic        s_tuser  = 1'b0;  // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] action_value, [8] beep, [9] key_learned,
                                   // [10] upgrade_request, [11] send_prompt, [15:12] zero
    logic [2:0]  m_tuser;          // [2:0] action
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int results_due;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // What the stimulus side knows about the block, so that it can build frames that line up
    // with the receiver's framing and carry the current key. This is only a guide for shaping
    // stimulus; the checker holds the real prediction.
    int                 frame_slot  = 0;
    int                 idle_ms     = 0;
    int                 words_sent  = 0;
    logic               key_known   = 1'b0;
    logic [7:0]         known_key   = '0;
    logic [TIMER_W-1:0] gap_limit   = GAP_TIMEOUT_RST;

    int quiet_cycles = 0;

    keyed_command_frame_receiver DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    kcfr_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The result side stalls at random, one decision per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog: any word moved on either stream or the register port restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one input word, after a random hold-off, and returns at the edge that takes it.
    // Valid stays high on return, so the next word can follow without a gap.
    task automatic send_word(input logic tick, input logic [7:0] rx, input logic link);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tick;
        s_tdata  <= {7'd0, link, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Keep the stimulus-side view of framing and key in step with what was sent.
        if (!link) key_known = 1'b0;
        if (tick) begin
            idle_ms++;
        end else begin
            if (idle_ms >= gap_limit) frame_slot = 0;
            frame_slot = (frame_slot + 1) % FRAME_LEN;
            idle_ms    = 0;
        end
        words_sent++;
    endtask

    // Sends four bytes as one frame with the link up. A key frame sent while no key is known
    // teaches the block a key, and that key is noted so later command frames can carry it.
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        logic [7:0] sel;
        int         sum;
        logic       was_keyless;
        was_keyless = !key_known;
        send_word(1'b0, b0, 1'b1);
        send_word(1'b0, b1, 1'b1);
        send_word(1'b0, b2, 1'b1);
        send_word(1'b0, b3, 1'b1);
        if (was_keyless && (b0 == KSEL_B1 || b0 == KSEL_B2 || b0 == KSEL_B3)) begin
            sel = (b0 == KSEL_B1) ? b1 : (b0 == KSEL_B2) ? b2 : b3;
            sum = 0;
            for (int i = 0; i < 8; i++) begin
                if (sel[i]) sum += KEY_WEIGHTS[8 * i +: 8];
            end
            known_key = 8'(sum);
            key_known = 1'b1;
        end
    endtask

    // Sends the upgrade text. A corrupted copy either has one wrong character or starts with a
    // doubled first character, which must not count because a mismatching byte is not retried.
    task automatic send_upgrade_text(input logic corrupt);
        int         bad_pos;
        logic [7:0] c;
        bad_pos = corrupt ? $urandom_range(0, UPG_LEN) : -1;
        if (bad_pos == UPG_LEN) send_word(1'b0, UPG_TEXT[8 * (UPG_LEN - 1) +: 8], 1'b1);
        for (int k = 0; k < UPG_LEN; k++) begin
            c = UPG_TEXT[8 * (UPG_LEN - 1 - k) +: 8];
            if (k == bad_pos) c = 8'($urandom_range(0, 255));
            send_word(1'b0, c, 1'b1);
        end
    endtask

    // Holds the sender back until every predicted result word has come out of the block.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // One register write: a setup phase, then an access phase that completes while pready is
    // high. The upper data bits carry noise, since the registers are only ten bits wide.
    task automatic write_register(input logic idx, input logic [TIMER_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {22'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GAP_TIMEOUT) gap_limit = value;
        @(posedge aclk);
    endtask

    initial begin
        logic [7:0]         b0, b1, b2, b3;
        logic [TIMER_W-1:0] tmo, period;
        int                 n;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words with the reset register values. A key frame whose selector takes the
        // last byte, set to all ones, gives the largest key. Then a heater command at the
        // largest setting whose check byte still fits, a channel command whose check sum only
        // matches after wrapping (rejected), and a valid frame with an unknown command byte.
        send_frame(KSEL_B3, 8'h00, 8'hff, 8'hff);
        send_frame(known_key, CMD_HEATER, 8'd85, 8'd254);
        send_frame(known_key, CMD_CH1, 8'hff, 8'(3 * CMD_CH1 + 2 * 8'hff));
        send_frame(known_key, 8'h00, 8'h00, 8'h00);
        // Dropping the link forgets the key; a key frame with a bad selector is then ignored.
        send_word(1'b1, 8'h00, 1'b0);
        send_frame(8'h00, 8'h01, 8'h02, 8'h03);
        send_upgrade_text(1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 66;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 66;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase

            // Registers change only with the block idle and every result word delivered.
            if (p != 0) begin
                wait_results_drained();
                case (p)
                    1: begin
                        tmo    = 10'd1;
                        period = 10'd1;
                    end
                    2: begin
                        tmo    = TIMER_MAX;
                        period = TIMER_MAX;
                    end
                    3: begin
                        tmo    = 10'd4;
                        period = 10'd9;
                    end
                    5: begin
                        tmo    = 10'($urandom_range(1, 12));
                        period = 10'($urandom_range(1, 30));
                    end
                    6: begin
                        tmo    = TIMER_MAX;
                        period = 10'd1;
                    end
                    default: begin
                        tmo    = 10'($urandom_range(1, 40));
                        period = 10'($urandom_range(1, 60));
                    end
                endcase
                write_register(REG_GAP_TIMEOUT, tmo);
                write_register(REG_PROMPT_PERIOD, period);
            end

            words_sent = 0;

            // With both registers at their top value, a long tick run drives the gap timer into
            // saturation: the prompt fires at the limit, and the next byte restarts the frame.
            if (p == 2) begin
                send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
                repeat (int'(TIMER_MAX) + 7) send_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end

            while (words_sent < WORDS_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // Fill up any partial frame first so the new frame lines up.
                        while (((idle_ms >= gap_limit) ? 0 : frame_slot) != 0) begin
                            send_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                        end
                        if (!key_known) begin
                            case ($urandom_range(0, 3))
                                0:       b0 = KSEL_B1;
                                1:       b0 = KSEL_B2;
                                2:       b0 = KSEL_B3;
                                default: b0 = 8'($urandom_range(0, 255));
                            endcase
                            b1 = 8'($urandom_range(0, 255));
                            b2 = 8'($urandom_range(0, 255));
                            b3 = 8'($urandom_range(0, 255));
                        end else begin
                            b0 = ($urandom_range(0, 99) < 85) ? known_key
                                                              : 8'($urandom_range(0, 255));
                            case ($urandom_range(0, 4))
                                0:       b1 = CMD_CH1;
                                1:       b1 = CMD_CH2;
                                2:       b1 = CMD_CH3;
                                3:       b1 = CMD_HEATER;
                                default: b1 = 8'($urandom_range(0, 255));
                            endcase
                            // Mostly a setting whose check sum fits in a byte, sometimes any.
                            if ($urandom_range(0, 99) < 80 && 3 * b1 <= 255) begin
                                b2 = 8'($urandom_range(0, (255 - 3 * b1) / 2));
                            end else begin
                                b2 = 8'($urandom_range(0, 255));
                            end
                            b3 = ($urandom_range(0, 99) < 85) ? 8'(3 * b1 + 2 * b2)
                                                              : 8'($urandom_range(0, 255));
                        end
                        send_frame(b0, b1, b2, b3);
                    end
                    4: begin
                        repeat ($urandom_range(1, 8)) begin
                            send_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                        end
                    end
                    5: begin
                        send_upgrade_text($urandom_range(0, 99) < 30);
                    end
                    6: begin
                        repeat ($urandom_range(1, 3)) begin
                            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                      1'b0);
                        end
                    end
                    7: begin
                        // With a gap timeout of at most 64, a tick run right at it, or one short of it, so the
                        // next byte lands on either side of the frame restart; otherwise one to eight ticks.
                        if (gap_limit <= 64) begin
                            n = int'(gap_limit) - int'($urandom_range(0, 1));
                        end else begin
                            n = $urandom_range(1, 8);
                        end
                        repeat (n) send_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
                    end
                    default: begin
                        repeat ($urandom_range(1, 4)) begin
                            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                      $urandom_range(0, 99) < 80);
                        end
                    end
                endcase
            end
        end

        // Let every outstanding word come out, then watch a little longer for strays.
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kcfr_pkg.sv
rtl/kcfr_cfg.sv
rtl/kcfr_core.sv
rtl/keyed_command_frame_receiver.sv
rtl/kcfr_checker.sv
dv/kcfr_checker.sv
dv/tb_keyed_command_frame_receiver.sv
